// ----- rtl/assert_macros.svh -----
// assertion macros shared by the calibration rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge out of reset
`define APC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");

// same-cycle implication
`define APC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication failed");

`endif

// ----- rtl/apc_pkg.sv -----
// constants, types and constant-divide helpers for the adc calibration unit
`default_nettype none

package apc_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int VAL_W       = 16;
	localparam int CODE_W      = 12;
	localparam int SEG_W       = 2;
	localparam int CFG_W       = 16;
	localparam int IDX_W       = 2;

	localparam logic [IDX_W-1:0] REG_FACTORY_OFFSET = 2'd0;
	localparam logic [IDX_W-1:0] REG_FACTORY_GAIN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_GROUND_OFFSET  = 2'd2;

	localparam logic [CFG_W-1:0] FACTORY_GAIN_RST = 16'd12050;

	localparam logic [SEG_W-1:0] SEG_MID = 2'd0;
	localparam logic [SEG_W-1:0] SEG_LO  = 2'd1;
	localparam logic [SEG_W-1:0] SEG_HI  = 2'd2;

	localparam logic [31:0] LOW_MV     = 32'd800;
	localparam logic [31:0] HIGH_MV    = 32'd2000;
	localparam logic [31:0] FULL_MV    = 32'd3300;
	localparam logic [31:0] GND_ADJUST = 32'd50;
	localparam logic [31:0] GAIN_SCALE = 32'd10000;
	localparam logic [31:0] MV_SCALE   = 32'd1000;
	localparam logic [23:0] CODE_MAX   = 24'd4095;

	// reciprocals for unsigned 32-bit division by small constants
	localparam logic [63:0] MAG10   = 64'h0000_0000_CCCC_CCCD;
	localparam logic [63:0] MAG1000 = 64'h0000_0000_1062_4DD3;
	localparam logic [63:0] MAG25   = 64'h0000_0000_51EB_851F;
	localparam logic [63:0] MAG13   = 64'h0000_0000_4EC4_EC4F;
	// ceil(2^36 / 3300), exact for products below 2^24
	localparam logic [48:0] MAG3300 = 49'd20824084;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [SEG_W-1:0] seg;
		logic             fault;
	} apc_side_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [SEG_W-1:0]  seg;
		logic              fault;
	} apc_res_t;

	function automatic logic [31:0] div10(input logic [31:0] x);
		logic [63:0] p;
		p = {32'b0, x} * MAG10;
		return 32'(p[63:35]);
	endfunction

	function automatic logic [31:0] div1000(input logic [31:0] x);
		logic [63:0] p;
		p = {32'b0, x} * MAG1000;
		return 32'(p[63:38]);
	endfunction

	function automatic logic [31:0] div25(input logic [31:0] x);
		logic [63:0] p;
		p = {32'b0, x} * MAG25;
		return 32'(p[63:35]);
	endfunction

	function automatic logic [31:0] div100(input logic [31:0] x);
		logic [63:0] p;
		p = {32'b0, x} * MAG25;
		return 32'(p[63:37]);
	endfunction

	function automatic logic [31:0] div13(input logic [31:0] x);
		logic [63:0] p;
		p = {32'b0, x} * MAG13;
		return 32'(p[63:34]);
	endfunction

	// millivolts limited to 0..3300, beyond that the code saturates anyway
	function automatic logic [CODE_W-1:0] clamp_mv(input logic [31:0] mv);
		logic [CODE_W-1:0] r;
		if (mv[31]) begin
			r = '0;
		end else if (mv >= FULL_MV) begin
			r = CODE_W'(FULL_MV);
		end else begin
			r = mv[CODE_W-1:0];
		end
		return r;
	endfunction

	// (mv * 4095) / 3300 from the registered product
	function automatic logic [CODE_W-1:0] code_of(input logic [23:0] prod);
		logic [48:0] p;
		p = {25'b0, prod} * MAG3300;
		return p[36+:CODE_W];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/apc_intf.sv -----
// valid/ready stream interfaces for samples and calibrated results
`default_nettype none

interface apc_in_if;
	import apc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_sample;
	modport source(output valid, output raw_sample, input ready);
	modport sink(input valid, input raw_sample, output ready);
endinterface

interface apc_out_if;
	import apc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] corrected_code;
	logic [SEG_W-1:0]  segment;
	logic              fault;
	modport source(output valid, output corrected_code, output segment, output fault,
		input ready);
	modport sink(input valid, input corrected_code, input segment, input fault,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/apc_sdiv.sv -----
// pipelined signed / positive divide, one quotient bit per stage
`default_nettype none

module apc_sdiv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [31:0]       num,
	input  wire logic [31:0]       den,
	input  wire apc_pkg::apc_side_t side_in,
	output logic                   out_valid,
	output logic [31:0]            quo,
	output apc_pkg::apc_side_t     side_out
);
	import apc_pkg::*;

	localparam int STEPS = 32;

	logic [STEPS:0]    vld_s;
	logic [31:0]       rem_s  [0:STEPS];
	logic [31:0]       acc_s  [0:STEPS];
	logic [31:0]       den_s  [0:STEPS];
	logic              neg_s  [0:STEPS];
	apc_side_t         side_s [0:STEPS];

	logic [32:0]       trial  [0:STEPS-1];
	logic              ge     [0:STEPS-1];
	logic [31:0]       nrem   [0:STEPS-1];
	logic [31:0]       nacc   [0:STEPS-1];

	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			trial[k] = {rem_s[k], acc_s[k][31]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
			nrem[k]  = ge[k] ? 32'(trial[k] - {1'b0, den_s[k]}) : trial[k][31:0];
			nacc[k]  = {acc_s[k][30:0], ge[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitude of the dividend, sign restored at the end
			rem_s[0]  <= '0;
			acc_s[0]  <= num[31] ? 32'(-num) : num;
			den_s[0]  <= den;
			neg_s[0]  <= num[31];
			side_s[0] <= side_in;
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k+1]  <= nrem[k];
				acc_s[k+1]  <= nacc[k];
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign quo       = neg_s[STEPS] ? 32'(-acc_s[STEPS]) : acc_s[STEPS];
	assign side_out  = side_s[STEPS];

endmodule

`default_nettype wire

// ----- rtl/adc_piecewise_calibration_unit.sv -----
// adc piecewise calibration unit: raw sample to calibrated 12-bit code
// an accepted sample passes s1, s2, the factory divider, s3, s4, the refit divider and s6 into the output buffer
// throughput: one sample per cycle while the output buffer is not full; two dividers of 32 quotient steps set the depth
// a two-entry output buffer keeps intake going while one result waits
// reset: async active low, clears valids and loads the factory fuse defaults
`default_nettype none
`include "assert_macros.svh"

module adc_piecewise_calibration_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [apc_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [apc_pkg::CFG_W-1:0]  cfg_wdata,
	apc_in_if.sink                          in_ch,
	apc_out_if.source                       out_ch
);
	import apc_pkg::*;

	// configuration
	logic [CFG_W-1:0] fo_q, fg_q, go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fo_q <= '0;
			fg_q <= FACTORY_GAIN_RST;
			go_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FACTORY_OFFSET: fo_q <= cfg_wdata;
				REG_FACTORY_GAIN:   fg_q <= cfg_wdata;
				REG_GROUND_OFFSET:  go_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// refit coefficients, free running, settled long before an item needs them
	logic [31:0] gofs_q, p8_q, p2_q, p33_q, q8_q, q2_q, q33_q;
	logic [31:0] s8_q, s2_q, sv_q, r8_q, rg_q, r2_q, rv_q;
	logic [31:0] dl_q, dh_q, ml_q, mh_q, gain_lo_q, h100_q, gain_hi_q;
	logic [31:0] t2k_q, r2x10_q, t2kd_q, ofs_hi_q;

	always_ff @(posedge clk) begin
		gofs_q    <= 32'(32'(go_q) - GND_ADJUST);
		p8_q      <= 32'(32'(fg_q) * LOW_MV);
		p2_q      <= 32'(32'(fg_q) * HIGH_MV);
		p33_q     <= 32'(32'(fg_q) * FULL_MV);
		q8_q      <= div1000(p8_q);
		q2_q      <= div1000(p2_q);
		q33_q     <= div1000(p33_q);
		s8_q      <= 32'(q8_q + 32'(fo_q));
		s2_q      <= 32'(q2_q + 32'(fo_q));
		sv_q      <= 32'(q33_q + gofs_q);
		r8_q      <= div10(s8_q);
		rg_q      <= div10(gofs_q);
		r2_q      <= div10(s2_q);
		rv_q      <= div10(sv_q);
		dl_q      <= 32'(r8_q - rg_q);
		dh_q      <= 32'(rv_q - r2_q);
		ml_q      <= 32'(dl_q * GAIN_SCALE);
		mh_q      <= 32'(dh_q * GAIN_SCALE);
		// divide by 800 as shift by 5 then by 25, by 1300 as 100 then 13
		gain_lo_q <= div25({5'b0, ml_q[31:5]});
		h100_q    <= div100(mh_q);
		gain_hi_q <= div13(h100_q);
		t2k_q     <= 32'(gain_hi_q * HIGH_MV);
		r2x10_q   <= 32'(r2_q * 32'd10);
		t2kd_q    <= div1000(t2k_q);
		ofs_hi_q  <= 32'(r2x10_q - t2kd_q);
	end

	// handshake and output buffer control
	logic       en;
	logic       acc;
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push, pop;

	assign en          = cnt_q != 2'd2;
	assign in_ch.ready = en;
	assign acc         = in_ch.valid && en;

	// item pipeline
	logic                   v_s1, v_s2, v_s3, v_s4, v_s6;
	logic [SAMPLE_BITS-1:0] raw_s1, raw_s2, raw_s3;
	logic [31:0]            num_s2, num_s4;
	logic                   fz_s2;
	logic [SEG_W-1:0]       seg_s3, seg_s4, seg_s6;
	logic [CODE_W-1:0]      mvc_s3, mvc_s4;
	logic                   fault_s3, fault_s4, fault_s6;
	logic [31:0]            gain_s3, ofs_s3, gain_s4;
	logic [23:0]            prod_s6;

	logic                   d1_v, d2_v;
	logic [31:0]            d1_q, d2_q;
	apc_side_t              d1_side_in, d1_side, d2_side_in, d2_side;
	logic [SEG_W-1:0]       seg_c;
	logic [CODE_W-1:0]      mvf_c;
	logic                   gpos_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= d1_v;
			v_s4 <= v_s3;
			v_s6 <= d2_v;
		end
	end

	assign d1_side_in = '{val: VAL_W'(raw_s2), seg: SEG_MID, fault: fz_s2};

	apc_sdiv u_div_fac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      (num_s2),
		.den      (32'(fg_q)),
		.side_in  (d1_side_in),
		.out_valid(d1_v),
		.quo      (d1_q),
		.side_out (d1_side)
	);

	// segment from factory millivolts: code <= code(800) iff mv <= 800, likewise 2000
	always_comb begin
		if (d1_side.fault || $signed(d1_q) <= $signed(LOW_MV)) begin
			seg_c = d1_side.fault ? SEG_MID : SEG_LO;
		end else if ($signed(d1_q) >= $signed(HIGH_MV)) begin
			seg_c = SEG_HI;
		end else begin
			seg_c = SEG_MID;
		end
	end

	assign gpos_c = !gain_s4[31] && gain_s4 != '0;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1   <= in_ch.raw_sample;
			raw_s2   <= raw_s1;
			num_s2   <= 32'(32'(raw_s1) * GAIN_SCALE) - 32'(32'(fo_q) * MV_SCALE);
			fz_s2    <= fg_q == '0;
			raw_s3   <= SAMPLE_BITS'(d1_side.val);
			seg_s3   <= seg_c;
			fault_s3 <= d1_side.fault;
			mvc_s3   <= clamp_mv(d1_q);
			case (seg_c)
				SEG_LO: begin
					gain_s3 <= gain_lo_q;
					ofs_s3  <= gofs_q;
				end
				SEG_HI: begin
					gain_s3 <= gain_hi_q;
					ofs_s3  <= ofs_hi_q;
				end
				default: begin
					gain_s3 <= 32'd1;
					ofs_s3  <= '0;
				end
			endcase
			num_s4   <= 32'(32'(raw_s3) * GAIN_SCALE) - 32'(ofs_s3 * MV_SCALE);
			gain_s4  <= gain_s3;
			seg_s4   <= seg_s3;
			fault_s4 <= fault_s3;
			mvc_s4   <= mvc_s3;
			prod_s6  <= 24'(mvf_c) * CODE_MAX;
			seg_s6   <= d2_side.seg;
			fault_s6 <= d2_side.fault;
		end
	end

	assign d2_side_in = '{val: VAL_W'(mvc_s4), seg: seg_s4,
		fault: fault_s4 || (seg_s4 != SEG_MID && !gpos_c)};

	apc_sdiv u_div_refit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (num_s4),
		.den      (gain_s4),
		.side_in  (d2_side_in),
		.out_valid(d2_v),
		.quo      (d2_q),
		.side_out (d2_side)
	);

	always_comb begin
		if (d2_side.fault) begin
			mvf_c = '0;
		end else if (d2_side.seg == SEG_MID) begin
			mvf_c = CODE_W'(d2_side.val);
		end else begin
			mvf_c = clamp_mv(d2_q);
		end
	end

	// two-entry output buffer
	apc_res_t skid_q [0:1];

	assign push = v_s6 && en;
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= 2'(cnt_q + 2'd1);
				2'b01:   cnt_q <= 2'(cnt_q - 2'd1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			skid_q[wr_q] <= '{code: code_of(prod_s6), seg: seg_s6, fault: fault_s6};
		end
	end

	assign out_ch.valid          = cnt_q != '0;
	assign out_ch.corrected_code = skid_q[rd_q].code;
	assign out_ch.segment        = skid_q[rd_q].seg;
	assign out_ch.fault          = skid_q[rd_q].fault;

	`APC_ASSERT_IMPL(a_fault_code, out_ch.valid && out_ch.fault, out_ch.corrected_code == '0)
	`APC_ASSERT_IMPL(a_seg_legal, out_ch.valid, out_ch.segment == SEG_MID || out_ch.segment == SEG_LO || out_ch.segment == SEG_HI)
	`APC_ASSERT(a_stall_hold, !en && v_s6 |=> v_s6 && $stable(prod_s6))
	`APC_ASSERT(a_cnt_range, cnt_q != 2'd3)

endmodule

`default_nettype wire
